### rtl/mep_pkg.sv
package mep_pkg;

  // Field and word widths.
  localparam int PIX_W      = 9;
  localparam int COLOR_W    = 8;
  localparam int ITER_W     = 12;
  localparam int Q_W        = 64;
  localparam int Q_FRAC     = 56;
  localparam int SCALE_W    = 63;
  localparam int PROD_W     = 2 * Q_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Image size as powers of two, so the mapping divide is a plain shift.
  localparam int IMG_W_LOG2 = 9;
  localparam int IMG_H_LOG2 = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_OFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_OFF   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 2'd3;

  // Q8.56 constants.
  localparam logic signed [Q_W-1:0] Q_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN     = 64'sh8000_0000_0000_0000;
  localparam logic signed [Q_W-1:0] Q_QUARTER = 64'sh0040_0000_0000_0000;
  localparam logic signed [Q_W-1:0] Q_ONE     = 64'sh0100_0000_0000_0000;
  localparam logic signed [Q_W-1:0] Q_NEG_ONE = 64'shFF00_0000_0000_0000;
  localparam logic signed [Q_W-1:0] Q_FOUR    = 64'sh0400_0000_0000_0000;

  // Register reset values: scale 2.0, real offset -0.5, imaginary offset 0.
  localparam logic [SCALE_W-1:0]    VIEW_SCALE_RST = 63'h0200_0000_0000_0000;
  localparam logic signed [Q_W-1:0] REAL_OFF_RST   = 64'shFF80_0000_0000_0000;
  localparam logic signed [Q_W-1:0] IMAG_OFF_RST   = 64'sh0;
  localparam logic [ITER_W-1:0]     MAX_ITER_RST   = 12'd30;

  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   out_x;
    logic [PIX_W-1:0]   out_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               escaped;
    logic [ITER_W-1:0]  escape_count;
  } pixel_out_t;

  // Color ramp floor(10*k*255/60) for k = 0..6 steps of ten degrees.
  function automatic logic [COLOR_W-1:0] ramp(input logic [2:0] k);
    logic [COLOR_W-1:0] v;
    case (k)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd42;
      3'd2:    v = 8'd85;
      3'd3:    v = 8'd127;
      3'd4:    v = 8'd170;
      3'd5:    v = 8'd212;
      default: v = COLOR_MAX;
    endcase
    return v;
  endfunction

endpackage

### rtl/mep_qmul.sv
module mep_qmul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [mep_pkg::Q_W-1:0]      op_a_i,
  input  logic signed [mep_pkg::Q_W-1:0]      op_b_i,
  output logic                                done_o,
  output logic [mep_pkg::PROD_W-1:0]          prod_o,
  output logic signed [mep_pkg::Q_W-1:0]      res_o
);
  import mep_pkg::*;

  localparam int HALF_W = Q_W / 2;
  localparam logic [2:0] CNT_LAST_PP = 3'd3;
  localparam logic [2:0] CNT_LAST_AC = 3'd4;
  localparam logic [2:0] CNT_FINAL   = 3'd5;

  logic                    busy_q;
  logic [2:0]              cnt_q;
  logic                    done_q;
  logic [Q_W-1:0]          mag_a_q, mag_b_q;
  logic                    neg_q;
  logic [Q_W-1:0]          pp_q;
  logic [1:0]              pp_sh_q;
  logic [PROD_W-1:0]       acc_q;
  logic signed [Q_W-1:0]   res_q;

  logic [HALF_W-1:0]       a_half, b_half;
  logic [Q_W-1:0]          pp_d;
  logic [PROD_W-1:0]       pp_al;
  logic [Q_W-1:0]          m;
  logic                    ovf, frac_nz;
  logic signed [Q_W-1:0]   res_d;

  function automatic logic [Q_W-1:0] mag(input logic signed [Q_W-1:0] v);
    return v[Q_W-1] ? (~v + 1'b1) : v;
  endfunction

  // One 32x32 partial product per cycle; the counter picks the halves.
  assign a_half = cnt_q[0] ? mag_a_q[Q_W-1:HALF_W] : mag_a_q[HALF_W-1:0];
  assign b_half = cnt_q[1] ? mag_b_q[Q_W-1:HALF_W] : mag_b_q[HALF_W-1:0];
  assign pp_d   = {{HALF_W{1'b0}}, a_half} * {{HALF_W{1'b0}}, b_half};

  // Align the registered partial product for the accumulator.
  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_al = {{Q_W{1'b0}}, pp_q};
      2'd1:    pp_al = {{HALF_W{1'b0}}, pp_q, {HALF_W{1'b0}}};
      default: pp_al = {pp_q, {Q_W{1'b0}}};
    endcase
  end

  // Scale back by the fraction bits, round toward minus infinity, saturate.
  // For a negative rounded result, -(m+1) is simply ~m.
  assign m       = acc_q[Q_FRAC +: Q_W];
  assign ovf     = |acc_q[PROD_W-1:Q_FRAC+Q_W-1];
  assign frac_nz = |acc_q[Q_FRAC-1:0];

  always_comb begin
    if (ovf) begin
      res_d = neg_q ? Q_MIN : Q_MAX;
    end else if (neg_q) begin
      res_d = frac_nz ? $signed(~m) : -$signed(m);
    end else begin
      res_d = $signed(m);
    end
  end

  // Sequencer of the partial products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_FINAL);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == CNT_FINAL) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand, product and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_a_q <= mag(op_a_i);
      mag_b_q <= mag(op_b_i);
      neg_q   <= op_a_i[Q_W-1] ^ op_b_i[Q_W-1];
      acc_q   <= '0;
    end else if (busy_q) begin
      if (cnt_q <= CNT_LAST_PP) begin
        pp_q    <= pp_d;
        pp_sh_q <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
      end
      if (cnt_q != 3'd0 && cnt_q <= CNT_LAST_AC) begin
        acc_q <= acc_q + pp_al;
      end
      if (cnt_q == CNT_FINAL) begin
        res_q <= res_d;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
  assign res_o  = res_q;

endmodule

### rtl/mandelbrot_escape_pixel.sv
// Escape-time pixel engine for a fractal image.
//
// Input channel (in_valid_i / in_ready_o / in_i) takes one pixel word with
// its column and row. Output channel (out_valid_o / out_ready_i / out_o)
// gives one word per pixel: the coordinates, the RGB color, the escape flag
// and the iteration of the escape. The block works on one pixel at a time
// and holds in_ready_o low until the pixel's result is in the output
// register.
// Every product runs through one shared 32x32 multiplier that builds each
// 64x64 Q8.56 product from four partial products. Mapping takes two
// products and the cardioid test three more; the test is skipped when the
// point is far from the cardioid. Each orbit iteration runs three products.
// If the receiver stalls, the result waits in the output register; the
// next pixel is still accepted, and its result waits until the register is
// free. The configuration port writes a register, and should be used only
// while no pixel is in work. Reset empties the block and restores the
// default view: scale 2.0, center -0.5, 30 iterations.
module mandelbrot_escape_pixel (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mep_pkg::pixel_in_t                   in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mep_pkg::pixel_out_t                  out_o,
  input  logic                                 cfg_we_i,
  input  logic [mep_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mep_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import mep_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_MAP_X     = 5'd1;
  localparam logic [4:0] S_ADD_X     = 5'd2;
  localparam logic [4:0] S_MAP_Y     = 5'd3;
  localparam logic [4:0] S_ADD_Y     = 5'd4;
  localparam logic [4:0] S_CARD_CHK  = 5'd5;
  localparam logic [4:0] S_CARD_YY   = 5'd6;
  localparam logic [4:0] S_CARD_XX   = 5'd7;
  localparam logic [4:0] S_CARD_Q    = 5'd8;
  localparam logic [4:0] S_CARD_T    = 5'd9;
  localparam logic [4:0] S_IT_LAUNCH = 5'd10;
  localparam logic [4:0] S_IT_P      = 5'd11;
  localparam logic [4:0] S_IT_Z      = 5'd12;
  localparam logic [4:0] S_IT_A      = 5'd13;
  localparam logic [4:0] S_IT_B      = 5'd14;
  localparam logic [4:0] S_IT_CHK    = 5'd15;
  localparam logic [4:0] S_DONE      = 5'd16;

  // Hue sectors of sixty degrees, and the ten degree steps inside one.
  localparam logic [2:0] SEC_YELLOW  = 3'd0;
  localparam logic [2:0] SEC_GREEN   = 3'd1;
  localparam logic [2:0] SEC_CYAN    = 3'd2;
  localparam logic [2:0] SEC_BLUE    = 3'd3;
  localparam logic [2:0] SEC_MAGENTA = 3'd4;
  localparam logic [2:0] SEC_LAST    = 3'd5;
  localparam logic [2:0] STEP_LAST   = 3'd5;
  localparam logic [2:0] RAMP_TOP    = 3'd6;

  localparam logic [PIX_W:0] HALF_X = (PIX_W+1)'(1 << (IMG_W_LOG2 - 1));
  localparam logic [PIX_W:0] HALF_Y = (PIX_W+1)'(1 << (IMG_H_LOG2 - 1));

  // Configuration registers.
  logic [SCALE_W-1:0]    view_scale_q;
  logic signed [Q_W-1:0] re_off_q, im_off_q;
  logic [ITER_W-1:0]     max_iter_q;

  // Sequencer and datapath registers.
  logic [4:0]            state_q, state_d;
  logic                  mul_go_q, mul_go_d;
  logic signed [Q_W-1:0] op_a_q, op_a_d, op_b_q, op_b_d;
  logic [PIX_W-1:0]      px_q, px_d, py_q, py_d;
  logic signed [Q_W-1:0] cr_q, cr_d, ci_q, ci_d;
  logic signed [Q_W-1:0] zr_q, zr_d, zi_q, zi_d;
  logic signed [Q_W-1:0] sq_re_q, sq_re_d, sq_im_q, sq_im_d;
  logic signed [Q_W-1:0] tmp_q, tmp_d;
  logic [ITER_W-1:0]     iter_q, iter_d;
  logic [2:0]            sector_q, sector_d, step_q, step_d;
  logic                  esc_q, esc_d;
  logic                  out_valid_q, out_valid_d;
  pixel_out_t            out_q, out_d;
  logic                  begin_iter;

  logic                  mul_done;
  logic [PROD_W-1:0]     mul_prod;
  logic signed [Q_W-1:0] mul_res;
  logic [COLOR_W-1:0]    up, dn, red, green, blue;

  function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      return s[Q_W] ? Q_MIN : Q_MAX;
    end
    return s[Q_W-1:0];
  endfunction

  function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} - {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) begin
      return s[Q_W] ? Q_MIN : Q_MAX;
    end
    return s[Q_W-1:0];
  endfunction

  function automatic logic signed [Q_W-1:0] sat_dbl(input logic signed [Q_W-1:0] a);
    if (a[Q_W-1] != a[Q_W-2]) begin
      return a[Q_W-1] ? Q_MIN : Q_MAX;
    end
    return {a[Q_W-2:0], 1'b0};
  endfunction

  // Twice the distance of a pixel from the image center, as a positive word.
  function automatic logic signed [Q_W-1:0] map_num(input logic [PIX_W-1:0] pix,
                                                    input logic [PIX_W:0] half);
    logic [PIX_W:0]   d;
    logic [PIX_W+1:0] num;
    d   = ({1'b0, pix} >= half) ? ({1'b0, pix} - half) : (half - {1'b0, pix});
    num = {d, 1'b0};
    return {{(Q_W-PIX_W-2){1'b0}}, num};
  endfunction

  // Scaled product to a signed coordinate, saturated at the 64-bit range.
  function automatic logic signed [Q_W-1:0] q_from_mag(input logic [PROD_W-1:0] sh,
                                                       input logic neg);
    logic           big;
    logic [Q_W-1:0] mv;
    big = |sh[PROD_W-1:Q_W-1];
    mv  = sh[Q_W-1:0];
    if (big) begin
      return neg ? Q_MIN : Q_MAX;
    end
    return neg ? -$signed(mv) : $signed(mv);
  endfunction

  mep_qmul u_qmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .op_a_i  (op_a_q),
    .op_b_i  (op_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod),
    .res_o   (mul_res)
  );

  // Color of the escape iteration from the tracked hue sector and step.
  assign up = ramp(step_q);
  assign dn = ramp(RAMP_TOP - step_q);

  always_comb begin
    case (sector_q)
      SEC_YELLOW:  begin red = COLOR_MAX; green = up;        blue = '0;        end
      SEC_GREEN:   begin red = dn;        green = COLOR_MAX; blue = '0;        end
      SEC_CYAN:    begin red = '0;        green = COLOR_MAX; blue = up;        end
      SEC_BLUE:    begin red = '0;        green = dn;        blue = COLOR_MAX; end
      SEC_MAGENTA: begin red = up;        green = '0;        blue = COLOR_MAX; end
      default:     begin red = COLOR_MAX; green = '0;        blue = dn;        end
    endcase
  end

  // Sequencer: mapping, cardioid test, then the orbit loop.
  always_comb begin
    state_d     = state_q;
    mul_go_d    = 1'b0;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    px_d        = px_q;
    py_d        = py_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    zr_d        = zr_q;
    zi_d        = zi_q;
    sq_re_d     = sq_re_q;
    sq_im_d     = sq_im_q;
    tmp_d       = tmp_q;
    iter_d      = iter_q;
    sector_d    = sector_q;
    step_d      = step_q;
    esc_d       = esc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    begin_iter  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          px_d     = in_i.pixel_x;
          py_d     = in_i.pixel_y;
          mul_go_d = 1'b1;
          op_a_d   = map_num(in_i.pixel_x, HALF_X);
          op_b_d   = {1'b0, view_scale_q};
          state_d  = S_MAP_X;
        end
      end
      S_MAP_X: begin
        if (mul_done) begin
          tmp_d   = q_from_mag(mul_prod >> IMG_W_LOG2, {1'b0, px_q} < HALF_X);
          state_d = S_ADD_X;
        end
      end
      S_ADD_X: begin
        cr_d     = sat_add(tmp_q, re_off_q);
        mul_go_d = 1'b1;
        op_a_d   = map_num(py_q, HALF_Y);
        op_b_d   = {1'b0, view_scale_q};
        state_d  = S_MAP_Y;
      end
      S_MAP_Y: begin
        if (mul_done) begin
          tmp_d   = q_from_mag(mul_prod >> IMG_H_LOG2, {1'b0, py_q} < HALF_Y);
          state_d = S_ADD_Y;
        end
      end
      S_ADD_Y: begin
        // The real part is kept shifted by a quarter for the cardioid test.
        ci_d    = sat_add(tmp_q, im_off_q);
        zr_d    = sat_sub(cr_q, Q_QUARTER);
        state_d = S_CARD_CHK;
      end
      S_CARD_CHK: begin
        if (zr_q <= Q_NEG_ONE || zr_q >= Q_ONE || ci_q <= Q_NEG_ONE || ci_q >= Q_ONE) begin
          begin_iter = 1'b1;
        end else begin
          mul_go_d = 1'b1;
          op_a_d   = ci_q;
          op_b_d   = ci_q;
          state_d  = S_CARD_YY;
        end
      end
      S_CARD_YY: begin
        if (mul_done) begin
          sq_im_d  = mul_res;
          mul_go_d = 1'b1;
          op_a_d   = zr_q;
          op_b_d   = zr_q;
          state_d  = S_CARD_XX;
        end
      end
      S_CARD_XX: begin
        if (mul_done) begin
          tmp_d   = sat_add(mul_res, sq_im_q);
          state_d = S_CARD_Q;
        end
      end
      S_CARD_Q: begin
        mul_go_d = 1'b1;
        op_a_d   = tmp_q;
        op_b_d   = sat_add(tmp_q, zr_q);
        state_d  = S_CARD_T;
      end
      S_CARD_T: begin
        if (mul_done) begin
          if (mul_res < (sq_im_q >>> 2)) begin
            esc_d   = 1'b0;
            state_d = S_DONE;
          end else begin
            begin_iter = 1'b1;
          end
        end
      end
      S_IT_LAUNCH: begin
        if (max_iter_q == '0) begin
          state_d = S_DONE;
        end else begin
          mul_go_d = 1'b1;
          op_a_d   = zr_q;
          op_b_d   = zi_q;
          state_d  = S_IT_P;
        end
      end
      S_IT_P: begin
        if (mul_done) begin
          tmp_d   = sat_dbl(mul_res);
          sq_re_d = sat_sub(sq_re_q, sq_im_q);
          state_d = S_IT_Z;
        end
      end
      S_IT_Z: begin
        zr_d     = sat_add(sq_re_q, cr_q);
        zi_d     = sat_add(tmp_q, ci_q);
        mul_go_d = 1'b1;
        op_a_d   = zr_d;
        op_b_d   = zr_d;
        state_d  = S_IT_A;
      end
      S_IT_A: begin
        if (mul_done) begin
          sq_re_d  = mul_res;
          mul_go_d = 1'b1;
          op_a_d   = zi_q;
          op_b_d   = zi_q;
          state_d  = S_IT_B;
        end
      end
      S_IT_B: begin
        if (mul_done) begin
          sq_im_d = mul_res;
          state_d = S_IT_CHK;
        end
      end
      S_IT_CHK: begin
        if (sat_add(sq_re_q, sq_im_q) >= Q_FOUR) begin
          esc_d   = 1'b1;
          state_d = S_DONE;
        end else if ((13'(iter_q) + 13'd1) == 13'(max_iter_q)) begin
          state_d = S_DONE;
        end else begin
          // Advance the hue by ten degrees along with the iteration count.
          iter_d = iter_q + 1'b1;
          if (step_q == STEP_LAST) begin
            step_d   = '0;
            sector_d = (sector_q == SEC_LAST) ? SEC_YELLOW : sector_q + 3'd1;
          end else begin
            step_d = step_q + 3'd1;
          end
          state_d = S_IT_LAUNCH;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.out_x        = px_q;
          out_d.out_y        = py_q;
          out_d.red          = esc_q ? red : '0;
          out_d.green        = esc_q ? green : '0;
          out_d.blue         = esc_q ? blue : '0;
          out_d.escaped      = esc_q;
          out_d.escape_count = esc_q ? iter_q : '0;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Start the orbit at zero with the hue at red.
    if (begin_iter) begin
      zr_d     = '0;
      zi_d     = '0;
      sq_re_d  = '0;
      sq_im_d  = '0;
      iter_d   = '0;
      sector_d = SEC_YELLOW;
      step_d   = '0;
      esc_d    = 1'b0;
      state_d  = S_IT_LAUNCH;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      sector_q    <= SEC_YELLOW;
      step_q      <= '0;
      esc_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_go_q    <= mul_go_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
      sector_q    <= sector_d;
      step_q      <= step_d;
      esc_q       <= esc_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_a_q  <= op_a_d;
    op_b_q  <= op_b_d;
    px_q    <= px_d;
    py_q    <= py_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    sq_re_q <= sq_re_d;
    sq_im_q <= sq_im_d;
    tmp_q   <= tmp_d;
    out_q   <= out_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_scale_q <= VIEW_SCALE_RST;
      re_off_q     <= REAL_OFF_RST;
      im_off_q     <= IMAG_OFF_RST;
      max_iter_q   <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIEW_SCALE: view_scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_REAL_OFF:   re_off_q     <= $signed(cfg_data_i);
        CFG_IMAG_OFF:   im_off_q     <= $signed(cfg_data_i);
        CFG_MAX_ITER:   max_iter_q   <= cfg_data_i[ITER_W-1:0];
        default:        ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### rtl/mep_sva.sv
module mep_sva (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input mep_pkg::pixel_in_t  in_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mep_pkg::pixel_out_t out_o
);
  import mep_pkg::*;

  // Once a pixel word is taken, the engine is busy in the cycle after.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an accept");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its contents.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_o))
    else $error("result changed while stalled");

  // A pixel that did not escape is plain black with no count.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.escaped |->
      out_o.red == '0 && out_o.green == '0 && out_o.blue == '0 &&
      out_o.escape_count == '0)
    else $error("interior pixel carries color or count");

  // A fully saturated hue always has one channel at full scale.
  a_hue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.escaped |->
      out_o.red == COLOR_MAX || out_o.green == COLOR_MAX || out_o.blue == COLOR_MAX)
    else $error("escaped pixel color has no full channel");

  // Input payload is watched only through the port list.
  logic unused_in;
  assign unused_in = ^in_i;

endmodule

bind mandelbrot_escape_pixel mep_sva u_mep_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

### bench/tb.sv
module tb;
  import mep_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;

  typedef logic signed [Q_W-1:0] q_t;

  // Tracks the view registers, predicts the word for each accepted pixel and
  // checks the words that come out against those predictions.
  class pixel_scoreboard;
    logic [SCALE_W-1:0] view_scale;
    q_t                 real_off;
    q_t                 imag_off;
    logic [ITER_W-1:0]  iter_limit;
    pixel_out_t         expected_pixels[$];
    int unsigned        mismatches;

    function new();
      view_scale = 63'h0200_0000_0000_0000;
      real_off   = 64'shFF80_0000_0000_0000;
      imag_off   = '0;
      iter_limit = 12'd30;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VIEW_SCALE: view_scale = data[SCALE_W-1:0];
        CFG_REAL_OFF:   real_off = data;
        CFG_IMAG_OFF:   imag_off = data;
        CFG_MAX_ITER:   iter_limit = data[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    // Sums and differences are formed one bit wider and clamped on overflow.
    function q_t sat_sum(q_t a, q_t b);
      logic [Q_W:0] s;
      s = {a[Q_W-1], a} + {b[Q_W-1], b};
      if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? Q_MIN : Q_MAX;
      return s[Q_W-1:0];
    endfunction

    function q_t sat_diff(q_t a, q_t b);
      logic [Q_W:0] s;
      s = {a[Q_W-1], a} - {b[Q_W-1], b};
      if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? Q_MIN : Q_MAX;
      return s[Q_W-1:0];
    endfunction

    // Full signed product, floored by the arithmetic shift, then clamped.
    function q_t fixed_mul(q_t a, q_t b);
      logic signed [PROD_W-1:0] wa;
      logic signed [PROD_W-1:0] wb;
      logic signed [PROD_W-1:0] prod;
      wa = a;
      wb = b;
      prod = (wa * wb) >>> Q_FRAC;
      if (prod[PROD_W-1:Q_W-1] != {(PROD_W-Q_W+1){prod[Q_W-1]}})
        return prod[PROD_W-1] ? Q_MIN : Q_MAX;
      return prod[Q_W-1:0];
    endfunction

    // Pixel to plane coordinate: the magnitude is truncated and clamped, then
    // the sign is applied and the offset added with saturation.
    function q_t map_coord(logic [PIX_W-1:0] pix, int lg, q_t off);
      int                d;
      logic [PROD_W-1:0] wnum;
      logic [PROD_W-1:0] wscale;
      logic [PROD_W-1:0] mag;
      q_t                v;
      d = int'(pix) - (1 << (lg - 1));
      wnum = (d < 0) ? -2 * d : 2 * d;
      wscale = view_scale;
      mag = (wnum * wscale) >> lg;
      if (mag[PROD_W-1:Q_W-1] != '0) begin
        v = (d < 0) ? Q_MIN : Q_MAX;
      end else begin
        v = mag[Q_W-1:0];
        if (d < 0) v = -v;
      end
      return sat_sum(v, off);
    endfunction

    // Main cardioid test in the form without a square root.
    function bit in_main_cardioid(q_t cr, q_t ci);
      q_t xs;
      q_t yy;
      q_t q;
      xs = sat_diff(cr, Q_QUARTER);
      if (xs <= Q_NEG_ONE || xs >= Q_ONE || ci <= Q_NEG_ONE || ci >= Q_ONE) return 1'b0;
      yy = fixed_mul(ci, ci);
      q = sat_sum(fixed_mul(xs, xs), yy);
      return fixed_mul(q, sat_sum(q, xs)) < (yy >>> 2);
    endfunction

    function pixel_out_t predict_pixel(pixel_in_t word);
      pixel_out_t r;
      q_t         cr;
      q_t         ci;
      q_t         zr;
      q_t         zi;
      q_t         nr;
      q_t         p;
      int         n;
      int         hue;
      int         ramp_pos;
      int         up;
      int         dn;
      r = '0;
      r.out_x = word.pixel_x;
      r.out_y = word.pixel_y;
      cr = map_coord(word.pixel_x, IMG_W_LOG2, real_off);
      ci = map_coord(word.pixel_y, IMG_H_LOG2, imag_off);
      if (in_main_cardioid(cr, ci)) return r;
      zr = '0;
      zi = '0;
      for (n = 0; n < int'(iter_limit); n++) begin
        nr = sat_sum(sat_diff(fixed_mul(zr, zr), fixed_mul(zi, zi)), cr);
        p = fixed_mul(zr, zi);
        zi = sat_sum(sat_sum(p, p), ci);
        zr = nr;
        if (sat_sum(fixed_mul(zr, zr), fixed_mul(zi, zi)) >= Q_FOUR) begin
          // Hue in steps of ten degrees, then six linear sectors.
          hue = (10 * n) % 360;
          ramp_pos = hue % 60;
          up = ramp_pos * 255 / 60;
          dn = (60 - ramp_pos) * 255 / 60;
          case (hue / 60)
            0: begin
              r.red = COLOR_MAX; r.green = up[COLOR_W-1:0]; r.blue = '0;
            end
            1: begin
              r.red = dn[COLOR_W-1:0]; r.green = COLOR_MAX; r.blue = '0;
            end
            2: begin
              r.red = '0; r.green = COLOR_MAX; r.blue = up[COLOR_W-1:0];
            end
            3: begin
              r.red = '0; r.green = dn[COLOR_W-1:0]; r.blue = COLOR_MAX;
            end
            4: begin
              r.red = up[COLOR_W-1:0]; r.green = '0; r.blue = COLOR_MAX;
            end
            default: begin
              r.red = COLOR_MAX; r.green = '0; r.blue = dn[COLOR_W-1:0];
            end
          endcase
          r.escaped = 1'b1;
          r.escape_count = n[ITER_W-1:0];
          return r;
        end
      end
      return r;
    endfunction

    function void note_pixel(pixel_in_t word);
      expected_pixels.push_back(predict_pixel(word));
    endfunction

    function void check_field(string name, pixel_out_t want, logic [31:0] exp_v,
                              logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: pixel (%0d,%0d) %s expected %0d actual %0d",
                 $time, want.out_x, want.out_y, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual x=%0d y=%0d",
                 $time, got.out_x, got.out_y);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      check_field("out_x", want, want.out_x, got.out_x);
      check_field("out_y", want, want.out_y, got.out_y);
      check_field("red", want, want.red, got.red);
      check_field("green", want, want.green, got.green);
      check_field("blue", want, want.blue, got.blue);
      check_field("escaped", want, want.escaped, got.escaped);
      check_field("escape_count", want, want.escape_count, got.escape_count);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  pixel_in_t             in_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  pixel_out_t            out_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pixel_scoreboard pixels;
  bit              idle_on = 1'b1;
  int              stall_left = 0;
  int unsigned     cycle_count = 0;

  mandelbrot_escape_pixel i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_i(in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o(out_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver back-pressure comes in bursts, drawn at random while idle_on is set.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every result word accepted by the receiver is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) pixels.check_pixel(out_o);
  end

  // Presents one pixel word, sometimes after an idle burst, and waits for it
  // to be taken.
  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    pixel_in_t word;
    word.pixel_x = x;
    word.pixel_y = y;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
    pixels.note_pixel(word);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_pixel(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
  endtask

  // Drops valid and waits until every predicted word has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixels.expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    pixels.set_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Loads a whole view once the block is empty. Unused upper bits of the
  // narrow registers carry random values.
  task automatic set_view(input logic [SCALE_W-1:0] scale, input q_t roff, input q_t ioff,
                          input logic [ITER_W-1:0] iters);
    logic [CFG_DATA_W-1:0] iter_word;
    iter_word = {$urandom, $urandom};
    iter_word[ITER_W-1:0] = iters;
    drain();
    write_reg(CFG_VIEW_SCALE, {1'($urandom), scale});
    write_reg(CFG_REAL_OFF, roff);
    write_reg(CFG_IMAG_OFF, ioff);
    write_reg(CFG_MAX_ITER, iter_word);
  endtask

  initial begin
    logic [SCALE_W-1:0] rnd_scale;
    q_t                 rnd_re;
    q_t                 rnd_im;
    int                 k;
    pixels = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default view out of reset: corners, cardioid center, cusp, the
    // period-two bulb, alternating bit patterns and a walk along the real
    // axis across escape counts.
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd0, 9'd511);
    send_pixel(9'd511, 9'd0);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd352, 9'd256);
    send_pixel(9'd192, 9'd256);
    send_pixel(9'h155, 9'h0AA);
    send_pixel(9'h0AA, 9'h155);
    for (k = 356; k <= 396; k += 8) send_pixel(9'(k), 9'd256);
    send_pixel(9'd300, 9'd160);
    send_pixel(9'd200, 9'd340);
    send_pixel(9'd260, 9'd150);
    run_random(120);

    // Zoom near the boundary for a spread of escape counts and hues.
    set_view(63'h0040_0000_0000_0000, 64'shFF40_0000_0000_0000,
             64'sh0019_9999_9999_999A, 12'd64);
    run_random(80);

    // Smallest scale with far offsets: every point escapes at once.
    set_view(63'd1, 64'shC000_0000_0000_0000, 64'sh4000_0000_0000_0000, 12'd4095);
    run_random(25);

    // Scale 64.0 with offsets of 4.25 on the real axis and -4.25 on the
    // imaginary axis, at the longest iteration limit.
    set_view(63'h4000_0000_0000_0000, 64'sh0440_0000_0000_0000,
             64'shFBC0_0000_0000_0000, 12'd4095);
    run_random(25);

    // Full-width extremes of scale and offsets, single iteration.
    set_view(63'h7FFF_FFFF_FFFF_FFFF, Q_MIN, Q_MAX, 12'd1);
    run_random(20);

    // An iteration limit of zero leaves every pixel black.
    set_view(63'h0200_0000_0000_0000, 64'shFF80_0000_0000_0000, '0, 12'd0);
    run_random(20);

    // Longest limit on a few chosen pixels, two of them never escaping.
    set_view(63'h0200_0000_0000_0000, 64'shFF80_0000_0000_0000, '0, 12'd4095);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd384, 9'd256);
    send_pixel(9'd192, 9'd256);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd353, 9'd256);

    // Just right of the cusp the orbit crawls out after thousands of steps,
    // which drives the top bits of the escape count.
    set_view(63'h0000_0010_0000_0000, 64'sh0040_0010_0000_0000, '0, 12'd4095);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd511, 9'd256);

    // Random views at moderate limits.
    repeat (5) begin
      rnd_scale = 63'({$urandom, $urandom} >> $urandom_range(1, 40));
      if (rnd_scale == '0) rnd_scale = 63'd1;
      rnd_re = $signed({$urandom, $urandom}) >>> $urandom_range(5, 12);
      rnd_im = $signed({$urandom, $urandom}) >>> $urandom_range(5, 12);
      set_view(rnd_scale, rnd_re, rnd_im, 12'($urandom_range(1, 48)));
      run_random(40);
    end

    // Back to the default view at full rate on both sides.
    set_view(63'h0200_0000_0000_0000, 64'shFF80_0000_0000_0000, '0, 12'd30);
    idle_on = 1'b0;
    run_random(80);

    drain();
    // Leave room for any stray word after the last expected one.
    repeat (100) @(posedge clk_i);
    if (pixels.mismatches == 0 && pixels.expected_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/mep_pkg.sv
rtl/mep_qmul.sv
rtl/mandelbrot_escape_pixel.sv
rtl/mep_sva.sv
bench/tb.sv
